// ----- sv/gbnr_pkg.sv -----
// shared types and constants of the go-back-n receiver acker
package gbnr_pkg;

    localparam int          SEQ_SPACE_DEF = 256;
    localparam logic [7:0]  DATA_BYTES    = 8'd64;
    localparam logic [8:0]  PREFIX_NONE   = 9'h1FF;
    localparam logic [7:0]  ACK_KEY_RST   = 8'd1;
    localparam int          IN_TDATA_W    = 40;
    localparam int          OUT_TDATA_W   = 40;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } state_t;

    // packed from the lowest bit up: packet_ok first
    typedef struct packed {
        logic [15:0] total_bytes;
        logic        transfer_done;
        logic [7:0]  ack_check;
        logic [7:0]  ack_seq;
        logic        ack_valid;
        logic        packet_ok;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

// ----- sv/gbnr_len_mem.sv -----
// length memory: one write port, one registered read port
module gbnr_len_mem #(
    parameter int DEPTH = gbnr_pkg::SEQ_SPACE_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [7:0]       wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [7:0]       rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/gbnr_ctrl.sv -----
// packet check, received map and contiguous prefix walk
module gbnr_ctrl #(
    parameter int SEQ_SPACE = gbnr_pkg::SEQ_SPACE_DEF,
    parameter int IDX_W     = $clog2(SEQ_SPACE)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_last,
    input  logic [7:0]           data_byte,
    input  logic [7:0]           seq_num,
    input  logic [7:0]           payload_len,
    input  logic                 last_flag,
    input  logic [7:0]           checksum_in,
    input  logic [7:0]           ack_key,
    input  logic                 out_free,
    output logic                 res_valid,
    output gbnr_pkg::res_t       res
);

    import gbnr_pkg::*;

    state_t             state_reg, state_next;
    logic [7:0]         sum_reg, sum_next;
    logic [8:0]         prefix_reg, prefix_next;
    logic [15:0]        total_reg, total_next;
    logic               final_known_reg, final_known_next;
    logic [7:0]         final_seq_reg, final_seq_next;
    logic               finished_reg, finished_next;
    logic               grew_reg, grew_next;
    logic               pend_reg, pend_next;
    logic [SEQ_SPACE-1:0] rcv_reg, rcv_next;

    logic [7:0]         sum_data;
    logic [7:0]         hdr_sum;
    logic               seq_in_space;
    logic               good;
    logic [IDX_W-1:0]   seq_idx;
    logic [8:0]         walk_next;
    logic               walk_hit;
    logic               accept;
    logic               done_now;
    logic [7:0]         seq_plus;
    logic [15:0]        prod;

    logic               mem_we;
    logic [7:0]         mem_wdata;
    logic               mem_re;
    logic [7:0]         mem_rdata;

    gbnr_len_mem #(
        .DEPTH (SEQ_SPACE),
        .IDX_W (IDX_W)
    ) u_len_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (seq_idx),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (walk_next[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    assign sum_data     = sum_reg + data_byte;
    assign hdr_sum      = sum_data + seq_num + payload_len + {7'd0, last_flag};
    assign seq_in_space = {1'b0, seq_num} < 9'(SEQ_SPACE);
    assign good         = (hdr_sum == checksum_in) && seq_in_space;
    assign seq_idx      = seq_num[IDX_W-1:0];
    assign mem_wdata    = (payload_len > DATA_BYTES) ? DATA_BYTES : payload_len;
    assign walk_next    = prefix_reg + 9'd1;
    assign walk_hit     = (walk_next < 9'(SEQ_SPACE)) && rcv_reg[walk_next[IDX_W-1:0]];
    assign in_ready     = (state_reg == ST_IDLE) && (!in_last || out_free);
    assign accept       = in_valid && in_ready;
    assign done_now     = final_known_reg && (prefix_reg != PREFIX_NONE) &&
                          (prefix_reg >= {1'b0, final_seq_reg});
    assign seq_plus     = prefix_reg[7:0] + 8'd1;
    assign prod         = {8'd0, ack_key} * {8'd0, seq_plus};

    always_comb begin
        state_next       = state_reg;
        sum_next         = sum_reg;
        prefix_next      = prefix_reg;
        total_next       = total_reg;
        final_known_next = final_known_reg;
        final_seq_next   = final_seq_reg;
        finished_next    = finished_reg;
        grew_next        = grew_reg;
        pend_next        = 1'b0;
        rcv_next         = rcv_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        res_valid        = 1'b0;
        res              = '0;

        if (pend_reg) begin
            total_next = total_reg + {8'd0, mem_rdata};
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!in_last) begin
                        sum_next = sum_data;
                    end else begin
                        sum_next = 8'd0;
                        if (!finished_reg && good) begin
                            if (!rcv_reg[seq_idx]) begin
                                rcv_next[seq_idx] = 1'b1;
                                mem_we            = 1'b1;
                            end
                            if (last_flag && !final_known_reg) begin
                                final_known_next = 1'b1;
                                final_seq_next   = seq_num;
                            end
                            grew_next  = 1'b0;
                            state_next = ST_WALK;
                        end else begin
                            res_valid         = 1'b1;
                            res.transfer_done = finished_reg;
                            res.total_bytes   = total_reg;
                        end
                    end
                end
            end
            ST_WALK: begin
                if (walk_hit) begin
                    mem_re      = 1'b1;
                    prefix_next = walk_next;
                    grew_next   = 1'b1;
                    pend_next   = 1'b1;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    res_valid         = 1'b1;
                    res.packet_ok     = 1'b1;
                    res.ack_valid     = grew_reg;
                    res.ack_seq       = grew_reg ? prefix_reg[7:0] : 8'd0;
                    res.ack_check     = grew_reg ? prod[7:0] : 8'd0;
                    res.transfer_done = done_now;
                    res.total_bytes   = total_reg;
                    finished_next     = done_now;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            sum_reg         <= 8'd0;
            prefix_reg      <= PREFIX_NONE;
            total_reg       <= 16'd0;
            final_known_reg <= 1'b0;
            final_seq_reg   <= 8'd0;
            finished_reg    <= 1'b0;
            grew_reg        <= 1'b0;
            pend_reg        <= 1'b0;
            rcv_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            sum_reg         <= sum_next;
            prefix_reg      <= prefix_next;
            total_reg       <= total_next;
            final_known_reg <= final_known_next;
            final_seq_reg   <= final_seq_next;
            finished_reg    <= finished_next;
            grew_reg        <= grew_next;
            pend_reg        <= pend_next;
            rcv_reg         <= rcv_next;
        end
    end

endmodule

// ----- sv/go_back_n_receiver_acker.sv -----
// Go-back-N receiver acker top level: stream ports, ack code register, result register.
// Payload beats are taken one per cycle while the controller is idle. After the
// end-of-packet beat of a good packet, the walk reads one stored length per cycle
// through the read port of the length memory as the contiguous prefix advances. A
// rejected or ignored packet yields its result without a walk. The received map is
// held in flip-flops cleared by reset, so no clearing pass follows reset. Results
// wait in an output register while payload beats go on.
module go_back_n_receiver_acker #(
    parameter int SEQ_SPACE = gbnr_pkg::SEQ_SPACE_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // data_byte[7:0], seq_num[15:8], payload_len[23:16], last_flag[24], checksum_in[32:25]
    input  logic [gbnr_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // packet_ok[0], ack_valid[1], ack_seq[9:2], ack_check[17:10],
    // transfer_done[18], total_bytes[34:19]
    output logic [gbnr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [7:0]                          cfg_data
);

    import gbnr_pkg::*;

    logic [7:0]  ack_key_reg;
    logic        m_tvalid_reg;
    res_t        res_reg;
    logic        out_free;
    logic        res_valid;
    res_t        res;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    gbnr_ctrl #(
        .SEQ_SPACE (SEQ_SPACE)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_last     (s_tlast),
        .data_byte   (s_tdata[7:0]),
        .seq_num     (s_tdata[15:8]),
        .payload_len (s_tdata[23:16]),
        .last_flag   (s_tdata[24]),
        .checksum_in (s_tdata[32:25]),
        .ack_key     (ack_key_reg),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_key_reg <= ACK_KEY_RST;
        end else if (cfg_valid && cfg_ready) begin
            ack_key_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_TDATA_W - RES_W)'(0), res_reg};

`ifndef SYNTHESIS
    property p_eop_needs_room;
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |-> (!m_tvalid || m_tready);
    endproperty
    a_eop_needs_room: assert property (p_eop_needs_room)
        else $error("end-of-packet beat taken while result register full");

    property p_ack_implies_ok;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[1] || m_tdata[0]);
    endproperty
    a_ack_implies_ok: assert property (p_ack_implies_ok)
        else $error("ack sent for a packet that was not taken");

    property p_no_ack_zero;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[1]) |-> (m_tdata[17:2] == 16'd0);
    endproperty
    a_no_ack_zero: assert property (p_no_ack_zero)
        else $error("ack fields not zero without an ack");
`endif

endmodule

// ----- tb/sv/go_back_n_receiver_acker_tb.sv -----
// self-checking testbench of the go-back-n receiver acker with its own packet predictor
module go_back_n_receiver_acker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gbnr_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       eop;
        logic [7:0] seq;
        logic [7:0] len;
        logic       last;
        logic [7:0] chk;
    } beat_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [7:0]             cfg_data = '0;

    go_back_n_receiver_acker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    beat_t       pending_beats[$];
    res_t        expected_reports[$];
    int          mismatches = 0;
    int          reports_seen = 0;
    bit          s_idle_on = 1'b1;
    bit          m_idle_on = 1'b1;
    int          s_gap = 0;
    int          m_stall = 0;

    // predictor state
    logic [7:0]  ack_key_now = ACK_KEY_RST;
    bit          seq_seen[256];
    logic [7:0]  stored_len[256];
    logic [7:0]  pkt_sum = '0;
    logic [8:0]  acked = PREFIX_NONE;
    bit          final_known = 1'b0;
    logic [7:0]  final_seq = '0;
    logic [15:0] bytes_acked = '0;
    bit          xfer_done = 1'b0;

    // sender state
    int          tx_next = 0;
    int          tx_window = 6;
    int          live_beats = 0;
    int          post_done_pkts = 0;
    bit          stim_over = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 0;
        else if (r < 96) return $urandom_range(1, 3);
        else return $urandom_range(8, 40);
    endfunction

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else return $urandom_range(40, 70);
    endfunction

    task automatic absorb_beat(input beat_t b);
        res_t       r;
        logic [7:0] s;
        int         nxt;
        bit         grew;
        r = '0;
        grew = 1'b0;
        if (!xfer_done) live_beats++;
        pending_beats.push_back(b);
        s = pkt_sum + b.data;
        if (!b.eop) begin
            pkt_sum = s;
        end else begin
            pkt_sum = '0;
            if (!xfer_done) begin
                s = s + b.seq + b.len + {7'd0, b.last};
                if (s == b.chk) begin
                    r.packet_ok = 1'b1;
                    if (!seq_seen[b.seq]) begin
                        seq_seen[b.seq] = 1'b1;
                        stored_len[b.seq] = (b.len > DATA_BYTES) ? DATA_BYTES : b.len;
                    end
                    if (b.last && !final_known) begin
                        final_known = 1'b1;
                        final_seq = b.seq;
                    end
                    nxt = (acked == PREFIX_NONE) ? 0 : int'(acked) + 1;
                    while (nxt < SEQ_SPACE_DEF && seq_seen[nxt]) begin
                        bytes_acked = bytes_acked + stored_len[nxt];
                        acked = 9'(nxt);
                        grew = 1'b1;
                        nxt++;
                    end
                    if (final_known && acked != PREFIX_NONE && acked >= {1'b0, final_seq})
                        xfer_done = 1'b1;
                end
            end
            r.ack_valid = grew;
            if (grew) begin
                r.ack_seq = acked[7:0];
                r.ack_check = ack_key_now * (acked[7:0] + 8'd1);
            end
            r.transfer_done = xfer_done;
            r.total_bytes = bytes_acked;
            expected_reports.push_back(r);
        end
    endtask

    // fill < 0 gives random payload bytes
    task automatic emit_packet(input logic [7:0] seq, input logic [7:0] len, input logic last,
                               input int nbytes, input int fill, input bit corrupt);
        beat_t      b;
        logic [7:0] sum;
        sum = '0;
        for (int i = 0; i < nbytes; i++) begin
            b.data = (fill < 0) ? 8'($urandom) : 8'(fill);
            sum = sum + b.data;
            b.eop = (i == nbytes - 1);
            if (b.eop) begin
                b.seq = seq;
                b.len = len;
                b.last = last;
                b.chk = sum + seq + len + {7'd0, last};
                if (corrupt) b.chk = b.chk ^ 8'($urandom_range(1, 255));
            end else begin
                b.seq = 8'($urandom);
                b.len = 8'($urandom);
                b.last = 1'($urandom);
                b.chk = 8'($urandom);
            end
            absorb_beat(b);
        end
    endtask

    task automatic emit_noise();
        logic [7:0] len;
        len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(65, 255))
                                           : 8'($urandom_range(0, 64));
        emit_packet(8'($urandom), len, ($urandom_range(0, 9) == 0), pick_size(), -1,
                    ($urandom_range(0, 3) != 0));
    endtask

    // one step of a go-back-n sender driven by the predicted cumulative ack
    task automatic sender_step();
        int base;
        int r;
        logic [7:0] len;
        if (xfer_done) begin
            emit_noise();
            post_done_pkts++;
            if (post_done_pkts >= 30) stim_over = 1'b1;
        end else begin
            base = (acked == PREFIX_NONE) ? 0 : int'(acked) + 1;
            if (tx_next < base) tx_next = base;
            if (tx_next >= base + tx_window || tx_next > 255) begin
                tx_next = base;
                tx_window = $urandom_range(4, 8);
            end
            len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(65, 255))
                                               : 8'($urandom_range(0, 64));
            r = $urandom_range(0, 99);
            if (r < 4) begin
                tx_next++;
            end else if (r < 8) begin
                emit_packet(8'(tx_next), len, 1'($urandom), pick_size(), -1, 1'b1);
                tx_next++;
            end else if (r < 13) begin
                emit_noise();
            end else begin
                emit_packet(8'(tx_next), len, ($urandom_range(0, 19) == 0), pick_size(), -1,
                            1'b0);
                tx_next++;
            end
            if (live_beats >= 2000) stim_over = 1'b1;
        end
    endtask

    task automatic settle();
        while (pending_beats.size() != 0 || s_tvalid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic set_ack_key(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        ack_key_now = v;
    endtask

    task automatic flag_field(input string fname, input logic [15:0] want_v,
                              input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, fname, want_v, got_v);
            mismatches++;
        end
    endtask

    // sender side
    always @(posedge aclk) begin
        beat_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_gap > 0) begin
                s_tvalid <= 1'b0;
                s_gap <= s_gap - 1;
            end else if (pending_beats.size() != 0) begin
                b = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {7'd0, b.chk, b.last, b.len, b.seq, b.data};
                s_tlast <= b.eop;
                s_gap <= s_idle_on ? pick_gap() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[RES_W-1:0]);
                if (expected_reports.size() == 0) begin
                    $display("%0t ns: unexpected result beat, expected none actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    flag_field("packet_ok", 16'(want.packet_ok), 16'(got.packet_ok));
                    flag_field("ack_valid", 16'(want.ack_valid), 16'(got.ack_valid));
                    flag_field("ack_seq", 16'(want.ack_seq), 16'(got.ack_seq));
                    flag_field("ack_check", 16'(want.ack_check), 16'(got.ack_check));
                    flag_field("transfer_done", 16'(want.transfer_done),
                               16'(got.transfer_done));
                    flag_field("total_bytes", want.total_bytes, got.total_bytes);
                end
                reports_seen++;
                // long hold-offs so the block backs up into its input
                if (reports_seen == 60 || reports_seen == 200) m_stall = 500;
                else if (m_idle_on) m_stall = pick_gap();
            end
            if (m_stall > 0) begin
                m_tready <= 1'b0;
                m_stall = m_stall - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int ph;
        int phase_start;
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed packets at the reset ack code
        emit_packet(8'd0, 8'd0, 1'b0, 1, 0, 1'b0);
        emit_packet(8'd1, 8'd10, 1'b0, 2, -1, 1'b1);
        emit_packet(8'd250, 8'd255, 1'b1, 2, 255, 1'b0);
        for (int s = 251; s <= 255; s++)
            emit_packet(8'(s), 8'($urandom), 1'b0, 1, -1, 1'b0);
        emit_packet(8'd0, 8'd50, 1'b0, 1, -1, 1'b0);
        emit_packet(8'd1, 8'd64, 1'b0, 1, -1, 1'b0);
        emit_packet(8'd2, 8'd65, 1'b0, 1, -1, 1'b0);
        emit_packet(8'd1, 8'd0, 1'b1, 1, -1, 1'b0);
        emit_packet(8'd4, 8'd255, 1'b0, 1, -1, 1'b0);
        emit_packet(8'd3, 8'd1, 1'b0, 2, -1, 1'b1);
        emit_packet(8'd3, 8'd1, 1'b0, 2, 255, 1'b0);

        ph = 0;
        while (!stim_over) begin
            settle();
            case (ph)
                0: set_ack_key(8'd0);
                1: set_ack_key(8'd255);
                default: set_ack_key(8'($urandom));
            endcase
            s_idle_on = (ph % 3 != 1);
            m_idle_on = (ph % 3 != 2);
            phase_start = live_beats;
            while (!stim_over && live_beats - phase_start < 250) sender_step();
            ph++;
        end
        settle();

        if (expected_reports.size() != 0) begin
            $display("%0t ns: %0d results expected, none arrived", $time,
                     expected_reports.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("go_back_n_receiver_acker verification clean");
        else
            $display("go_back_n_receiver_acker verification failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("%0t ns: timeout", $time);
        $display("go_back_n_receiver_acker verification failed");
        $finish;
    end

endmodule
